// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shapes for the checkers of the ray/wall crossing block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RWPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RWPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rwpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwpc_pkg
// Beat types, fixed-point constants and helpers for the ray/wall crossing.
// ----------------------------------------------------------------------------
package rwpc_pkg;

    localparam int MOUNT_REGS = 4;
    localparam int QUOT_BITS  = 47;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] NEAR_ZERO   = 32'sd16384;
    localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
    localparam logic [46:0]        QUOT_LIMIT  = 47'h2000_0000_0000;

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic [15:0]        pose_heading;
        logic [1:0]         sensor_index;
        logic               wall_vertical;
        logic signed [15:0] wall_face;
        logic signed [15:0] wall_base;
    } ray_beat_t;

    typedef struct packed {
        logic signed [31:0] hit_offset;
        logic signed [31:0] ray_range;
        logic signed [31:0] jac_x;
        logic signed [31:0] jac_y;
        logic signed [31:0] jac_heading;
        logic               saturated;
    } hit_beat_t;

    // arctan(2^-i) as a binary angle, Q0.32 turn scale
    function automatic logic signed [31:0] atan_step(input logic [4:0] i);
        case (i)
            5'd0:    return 32'sd536870912;
            5'd1:    return 32'sd316933406;
            5'd2:    return 32'sd167458907;
            5'd3:    return 32'sd85004756;
            5'd4:    return 32'sd42667331;
            5'd5:    return 32'sd21354465;
            5'd6:    return 32'sd10679838;
            5'd7:    return 32'sd5340245;
            5'd8:    return 32'sd2670163;
            5'd9:    return 32'sd1335087;
            5'd10:   return 32'sd667544;
            5'd11:   return 32'sd333772;
            5'd12:   return 32'sd166886;
            5'd13:   return 32'sd83443;
            5'd14:   return 32'sd41721;
            5'd15:   return 32'sd20860;
            5'd16:   return 32'sd10430;
            5'd17:   return 32'sd5215;
            5'd18:   return 32'sd2607;
            5'd19:   return 32'sd1303;
            5'd20:   return 32'sd651;
            5'd21:   return 32'sd325;
            5'd22:   return 32'sd162;
            5'd23:   return 32'sd81;
            default: return 32'sd0;
        endcase
    endfunction

    // clamp to 32 bits; bit 32 flags a clamp
    function automatic logic [32:0] emit32(input logic signed [63:0] w);
        if (w > 64'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        else if (w < -64'sd2147483648)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, w[31:0]};
    endfunction

endpackage

// ===== rtl/core/ray_wall_plane_crossing.sv =====
// ----------------------------------------------------------------------------
// ray_wall_plane_crossing
// Sensor ray against an axis-aligned wall plane: offset, range, pose Jacobian.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 beat
//  ray      in         ray_valid / ray_stall     ray_beat_t (pose, sensor, wall)
//  hit      out        hit_valid / hit_stall     hit_beat_t (offset, range, jac)
//  apb      in         psel/penable/pwrite       sensor mount x, y, angle
//
//  One ray per cycle unless a stalled hit beat holds the pipeline.
//  Each ray passes through the two CORDIC pipelines and the 47-step divider lanes.
//  rst_n clears the valid line and the mounting registers (async, active low).
//  A stalled hit beat freezes the whole pipeline; ray_stall follows it.
// ----------------------------------------------------------------------------
module ray_wall_plane_crossing
    import rwpc_pkg::*;
#(
    parameter int NUM_SENSORS   = 4,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        ray_valid,
    output logic        ray_stall,
    input  ray_beat_t   ray_beat,
    output logic        hit_valid,
    input  logic        hit_stall,
    output hit_beat_t   hit_beat
);

    localparam int CORDIC_LAT = CORDIC_STAGES + 2;
    localparam int DIV_LAT    = QUOT_BITS + 1;
    localparam int NSTG       = CORDIC_LAT + DIV_LAT + 7;
    localparam logic [1:0] LAST_SENSOR = 2'(NUM_SENSORS - 1);

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [15:0] mount_x;
        logic signed [15:0] mount_y;
        logic signed [15:0] wall_face;
        logic signed [15:0] wall_base;
        logic               wall_vertical;
    } front_t;

    typedef struct packed {
        logic signed [27:0] start;
        logic signed [15:0] wall_base;
        logic signed [26:0] lever_x;
        logic signed [26:0] lever_y;
        logic               wall_vertical;
        logic               sat;
        logic               neg_a;
        logic               neg_b;
        logic               neg_c;
        logic               neg_d;
        logic               neg_e;
    } back_t;

    // ---- handshake: one global advance, valid bits ride alongside the data
    logic [NSTG-1:0] valid_reg;
    logic            en;

    assign en        = !(valid_reg[NSTG-1] && hit_stall);
    assign ray_stall = !en;
    assign hit_valid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NSTG-2:0], ray_valid};
    end

    // ---- mounting registers, 64-bit APB slots at 8*i
    logic [47:0] mount_reg [0:MOUNT_REGS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOUNT_REGS; i++)
                mount_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
            mount_reg[paddr[4:3]] <= pwdata[47:0];
    end

    assign prdata = {16'b0, mount_reg[paddr[4:3]]};
    assign pready = 1'b1;

    // ---- S0: input register, mount lookup, ray angle
    ray_beat_t   s0_beat_reg;
    logic [1:0]  s0_sel;
    logic [47:0] s0_mount;
    logic [15:0] s0_ray_angle;
    front_t      s0_front;

    always_ff @(posedge clk)
    begin
        if (en)
            s0_beat_reg <= ray_beat;
    end

    // sensor indexes past the fitted count fall back to the last sensor
    always_comb
    begin
        s0_sel       = (s0_beat_reg.sensor_index > LAST_SENSOR) ? LAST_SENSOR
                                                                : s0_beat_reg.sensor_index;
        s0_mount     = mount_reg[s0_sel];
        s0_ray_angle = s0_beat_reg.pose_heading + s0_mount[47:32];
        s0_front.pose_x        = s0_beat_reg.pose_x;
        s0_front.pose_y        = s0_beat_reg.pose_y;
        s0_front.mount_x       = s0_mount[15:0];
        s0_front.mount_y       = s0_mount[31:16];
        s0_front.wall_face     = s0_beat_reg.wall_face;
        s0_front.wall_base     = s0_beat_reg.wall_base;
        s0_front.wall_vertical = s0_beat_reg.wall_vertical;
    end

    // ---- sin/cos of heading and of ray direction
    logic signed [31:0] ch, sh, dc, ds;

    rwpc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_head (
        .clk   (clk),
        .en    (en),
        .angle (s0_beat_reg.pose_heading),
        .cos_q (ch),
        .sin_q (sh)
    );

    rwpc_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ray (
        .clk   (clk),
        .en    (en),
        .angle (s0_ray_angle),
        .cos_q (dc),
        .sin_q (ds)
    );

    front_t front_reg [0:CORDIC_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg[0] <= s0_front;
            for (int i = 1; i < CORDIC_LAT; i++)
                front_reg[i] <= front_reg[i-1];
        end
    end

    // ---- P1: mount rotation products, across/along pick, near-zero guard
    front_t             fc;
    logic signed [47:0] p1_mxc_reg, p1_mys_reg, p1_mxs_reg, p1_myc_reg;
    logic signed [31:0] p1_across_reg, p1_along_reg;
    logic               p1_sat_reg;
    front_t             p1_front_reg;
    logic signed [31:0] p1_across_raw, p1_across_next, p1_along_next;
    logic               p1_sat_next;

    assign fc = front_reg[CORDIC_LAT-1];

    always_comb
    begin
        p1_across_raw  = fc.wall_vertical ? dc : ds;
        p1_along_next  = fc.wall_vertical ? ds : dc;
        p1_across_next = p1_across_raw;
        p1_sat_next    = 1'b0;
        // divisor too small: force +-2^-16, zero counts as positive
        if (p1_across_raw > -NEAR_ZERO && p1_across_raw < NEAR_ZERO)
        begin
            p1_across_next = p1_across_raw[31] ? -NEAR_ZERO : NEAR_ZERO;
            p1_sat_next    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_mxc_reg    <= 48'(fc.mount_x) * 48'(ch);
            p1_mys_reg    <= 48'(fc.mount_y) * 48'(sh);
            p1_mxs_reg    <= 48'(fc.mount_x) * 48'(sh);
            p1_myc_reg    <= 48'(fc.mount_y) * 48'(ch);
            p1_across_reg <= p1_across_next;
            p1_along_reg  <= p1_along_next;
            p1_sat_reg    <= p1_sat_next;
            p1_front_reg  <= fc;
        end
    end

    // ---- P2: sensor origin in world frame, across squared
    logic signed [48:0] p2_dx, p2_dy;
    logic signed [26:0] p2_lever_x_next, p2_lever_y_next;
    logic signed [23:0] p2_px, p2_py;
    logic signed [27:0] p2_ox_reg, p2_oy_reg;
    logic signed [26:0] p2_lever_x_reg, p2_lever_y_reg;
    logic signed [31:0] p2_across_reg, p2_along_reg;
    logic signed [63:0] p2_sq;
    logic [62:0]        p2_across2_reg;
    logic               p2_sat_reg;
    front_t             p2_front_reg;

    always_comb
    begin
        p2_dx           = 49'(p1_mxc_reg) - 49'(p1_mys_reg);
        p2_dy           = 49'(p1_mxs_reg) + 49'(p1_myc_reg);
        p2_lever_x_next = 27'(p2_dx >>> 22);
        p2_lever_y_next = 27'(p2_dy >>> 22);
        p2_px           = {p1_front_reg.pose_x, 8'b0};
        p2_py           = {p1_front_reg.pose_y, 8'b0};
        p2_sq           = 64'(p1_across_reg) * 64'(p1_across_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_ox_reg      <= 28'(p2_px) + 28'(p2_lever_x_next);
            p2_oy_reg      <= 28'(p2_py) + 28'(p2_lever_y_next);
            p2_lever_x_reg <= p2_lever_x_next;
            p2_lever_y_reg <= p2_lever_y_next;
            p2_across_reg  <= p1_across_reg;
            p2_along_reg   <= p1_along_reg;
            p2_across2_reg <= p2_sq[62:0];
            p2_sat_reg     <= p1_sat_reg;
            p2_front_reg   <= p1_front_reg;
        end
    end

    // ---- P3: gap to plane, start along wall, numerator products
    logic signed [23:0] p3_face;
    logic signed [28:0] p3_gap_next;
    logic signed [26:0] p3_lever_sel;
    logic signed [28:0] p3_gap_reg;
    logic signed [27:0] p3_start_reg;
    logic signed [60:0] p3_prod_a_reg;
    logic signed [58:0] p3_prod_e_reg;
    logic signed [31:0] p3_across_reg, p3_along_reg;
    logic [62:0]        p3_across2_reg;
    logic signed [26:0] p3_lever_x_reg, p3_lever_y_reg;
    logic signed [15:0] p3_wall_base_reg;
    logic               p3_vertical_reg, p3_sat_reg;

    always_comb
    begin
        p3_face      = {p2_front_reg.wall_face, 8'b0};
        p3_gap_next  = 29'(p3_face)
                     - 29'(p2_front_reg.wall_vertical ? p2_ox_reg : p2_oy_reg);
        p3_lever_sel = p2_front_reg.wall_vertical ? p2_lever_y_reg : p2_lever_x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_gap_reg       <= p3_gap_next;
            p3_start_reg     <= p2_front_reg.wall_vertical ? p2_oy_reg : p2_ox_reg;
            p3_prod_a_reg    <= 61'(p3_gap_next) * 61'(p2_along_reg);
            p3_prod_e_reg    <= 59'(p3_lever_sel) * 59'(p2_along_reg);
            p3_across_reg    <= p2_across_reg;
            p3_along_reg     <= p2_along_reg;
            p3_across2_reg   <= p2_across2_reg;
            p3_lever_x_reg   <= p2_lever_x_reg;
            p3_lever_y_reg   <= p2_lever_y_reg;
            p3_wall_base_reg <= p2_front_reg.wall_base;
            p3_vertical_reg  <= p2_front_reg.wall_vertical;
            p3_sat_reg       <= p2_sat_reg;
        end
    end

    // ---- P4: sign/magnitude split for the five divider lanes
    logic [28:0] p4_gap_mag;
    logic [31:0] p4_along_mag;
    logic        p4_acr_neg;
    back_t       p4_side_next;
    logic [60:0] p4_num_a_reg;
    logic [58:0] p4_num_b_reg;
    logic [47:0] p4_num_c_reg;
    logic [88:0] p4_num_d_reg;
    logic [58:0] p4_num_e_reg;
    logic [31:0] p4_den_reg;
    logic [62:0] p4_den_d_reg;
    back_t       p4_side_reg;

    always_comb
    begin
        p4_gap_mag   = p3_gap_reg[28] ? 29'(-p3_gap_reg) : 29'(p3_gap_reg);
        p4_along_mag = p3_along_reg[31] ? 32'(-p3_along_reg) : 32'(p3_along_reg);
        p4_acr_neg   = p3_across_reg[31];
        p4_side_next.start         = p3_start_reg;
        p4_side_next.wall_base     = p3_wall_base_reg;
        p4_side_next.lever_x       = p3_lever_x_reg;
        p4_side_next.lever_y       = p3_lever_y_reg;
        p4_side_next.wall_vertical = p3_vertical_reg;
        p4_side_next.sat           = p3_sat_reg;
        p4_side_next.neg_a         = p3_prod_a_reg[60] ^ p4_acr_neg;
        p4_side_next.neg_b         = p3_gap_reg[28] ^ p4_acr_neg;
        p4_side_next.neg_c         = p3_along_reg[31] ^ p4_acr_neg;
        p4_side_next.neg_d         = p3_gap_reg[28];
        p4_side_next.neg_e         = p3_prod_e_reg[58] ^ p4_acr_neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_num_a_reg <= p3_prod_a_reg[60] ? 61'(-p3_prod_a_reg) : 61'(p3_prod_a_reg);
            p4_num_b_reg <= {p4_gap_mag, 30'b0};
            p4_num_c_reg <= {p4_along_mag, 16'b0};
            p4_num_d_reg <= {p4_gap_mag, 60'b0};
            p4_num_e_reg <= p3_prod_e_reg[58] ? 59'(-p3_prod_e_reg) : 59'(p3_prod_e_reg);
            p4_den_reg   <= p4_acr_neg ? 32'(-p3_across_reg) : 32'(p3_across_reg);
            p4_den_d_reg <= p3_across2_reg;
            p4_side_reg  <= p4_side_next;
        end
    end

    // ---- divider lanes: a offset term, b range, c slope, d swing, e lever term
    logic [QUOT_BITS-1:0] q_a, q_b, q_c, q_d, q_e;
    logic                 big_a, big_b, big_c, big_d, big_e;

    rwpc_div #(.NW(61), .DW(32)) u_div_a (
        .clk (clk), .en (en), .num (p4_num_a_reg), .den (p4_den_reg),
        .quo (q_a), .big (big_a)
    );

    rwpc_div #(.NW(59), .DW(32)) u_div_b (
        .clk (clk), .en (en), .num (p4_num_b_reg), .den (p4_den_reg),
        .quo (q_b), .big (big_b)
    );

    rwpc_div #(.NW(48), .DW(32)) u_div_c (
        .clk (clk), .en (en), .num (p4_num_c_reg), .den (p4_den_reg),
        .quo (q_c), .big (big_c)
    );

    rwpc_div #(.NW(89), .DW(63)) u_div_d (
        .clk (clk), .en (en), .num (p4_num_d_reg), .den (p4_den_d_reg),
        .quo (q_d), .big (big_d)
    );

    rwpc_div #(.NW(59), .DW(32)) u_div_e (
        .clk (clk), .en (en), .num (p4_num_e_reg), .den (p4_den_reg),
        .quo (q_e), .big (big_e)
    );

    back_t back_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            back_reg[0] <= p4_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
                back_reg[i] <= back_reg[i-1];
        end
    end

    // clamp to 2^45, apply sign; bit 48 flags the clamp
    function automatic logic [48:0] fix_quot(input logic [QUOT_BITS-1:0] q,
                                             input logic big,
                                             input logic neg);
        logic        ovf;
        logic [47:0] mag;
        ovf = big || (q > QUOT_LIMIT);
        mag = {1'b0, ovf ? QUOT_LIMIT : q};
        return {ovf, neg ? 48'(-mag) : mag};
    endfunction

    // ---- P5: signed quotients and output sums
    back_t              bs;
    logic [48:0]        f_a, f_b, f_c, f_d, f_e;
    logic signed [47:0] v_a, v_b, v_c, v_d, v_e;
    logic signed [23:0] p5_base;
    logic signed [49:0] p5_jh_next;
    logic signed [49:0] p5_offset_reg;
    logic signed [47:0] p5_range_reg;
    logic signed [48:0] p5_nslope_reg;
    logic signed [49:0] p5_jh_reg;
    logic               p5_vertical_reg, p5_sat_reg;

    assign bs = back_reg[DIV_LAT-1];

    always_comb
    begin
        f_a     = fix_quot(q_a, big_a, bs.neg_a);
        f_b     = fix_quot(q_b, big_b, bs.neg_b);
        f_c     = fix_quot(q_c, big_c, bs.neg_c);
        f_d     = fix_quot(q_d, big_d, bs.neg_d);
        f_e     = fix_quot(q_e, big_e, bs.neg_e);
        v_a     = f_a[47:0];
        v_b     = f_b[47:0];
        v_c     = f_c[47:0];
        v_d     = f_d[47:0];
        v_e     = f_e[47:0];
        p5_base = {bs.wall_base, 8'b0};
        if (bs.wall_vertical)
            p5_jh_next = 50'(bs.lever_x) + 50'(v_e) + 50'(v_d);
        else
            p5_jh_next = -50'(bs.lever_y) - 50'(v_e) - 50'(v_d);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_offset_reg   <= 50'(bs.start) - 50'(p5_base) + 50'(v_a);
            p5_range_reg    <= v_b;
            p5_nslope_reg   <= 49'sd0 - 49'(v_c);
            p5_jh_reg       <= p5_jh_next;
            p5_vertical_reg <= bs.wall_vertical;
            p5_sat_reg      <= bs.sat | f_a[48] | f_b[48] | f_c[48] | f_d[48] | f_e[48];
        end
    end

    // ---- output register: drop to Q16.16 and clamp to 32 bits
    logic [32:0] e_off, e_rng, e_slope, e_jh;
    hit_beat_t   hit_next;
    hit_beat_t   hit_reg;

    always_comb
    begin
        e_off   = emit32(64'(p5_offset_reg >>> 4));
        e_rng   = emit32(64'(p5_range_reg >>> 4));
        e_slope = emit32(64'(p5_nslope_reg));
        e_jh    = emit32(64'(p5_jh_reg >>> 4));
        hit_next.hit_offset  = e_off[31:0];
        hit_next.ray_range   = e_rng[31:0];
        hit_next.jac_x       = p5_vertical_reg ? e_slope[31:0] : ONE_Q16;
        hit_next.jac_y       = p5_vertical_reg ? ONE_Q16 : e_slope[31:0];
        hit_next.jac_heading = e_jh[31:0];
        hit_next.saturated   = p5_sat_reg | e_off[32] | e_rng[32] | e_slope[32] | e_jh[32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= hit_next;
    end

    assign hit_beat = hit_reg;

endmodule

// ===== rtl/core/rwpc_cordic.sv =====
// ----------------------------------------------------------------------------
// rwpc_cordic
// Pipelined rotation-mode CORDIC: binary angle in, Q2.30 cos/sin out.
// ----------------------------------------------------------------------------
module rwpc_cordic
    import rwpc_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [31:0] cos_q,
    output logic signed [31:0] sin_q
);

    logic signed [31:0] x_reg [0:STAGES];
    logic signed [31:0] y_reg [0:STAGES];
    logic signed [31:0] z_reg [0:STAGES];
    logic               flip_reg [0:STAGES];
    logic signed [31:0] x_next [0:STAGES-1];
    logic signed [31:0] y_next [0:STAGES-1];
    logic signed [31:0] z_next [0:STAGES-1];
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic               flip_in;
    logic signed [31:0] z_in;

    // second and third quadrant: rotate half a turn, negate at the end
    always_comb
    begin
        flip_in = angle[15] ^ angle[14];
        z_in    = {angle[15] ^ flip_in, angle[14:0], 16'b0};
    end

    always_comb
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            if (!z_reg[i][31])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - atan_step(5'(i));
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + atan_step(5'(i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_in;
            flip_reg[0] <= flip_in;
            for (int i = 0; i < STAGES; i++)
            begin
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                z_reg[i+1]    <= z_next[i];
                flip_reg[i+1] <= flip_reg[i];
            end
            cos_reg <= flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
            sin_reg <= flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ===== rtl/core/rwpc_div.sv =====
// ----------------------------------------------------------------------------
// rwpc_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module rwpc_div
    import rwpc_pkg::*;
#(
    parameter int NW = 61,
    parameter int DW = 32
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    output logic [QUOT_BITS-1:0] quo,
    output logic                 big
);

    localparam int QB = QUOT_BITS;
    localparam int HW = NW - QB;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] rem_reg [0:QB-1];
    logic [QB-1:0] low_reg [0:QB-1];
    logic [DW-1:0] den_reg [0:QB-1];
    logic [QB-1:0] q_reg   [0:QB];
    logic          big_reg [0:QB];
    logic [DW:0]   trial   [0:QB-1];
    logic          fits    [0:QB-1];
    logic [DW-1:0] rem_next [0:QB-1];

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            trial[k]    = {rem_reg[k], low_reg[k][QB-1]};
            fits[k]     = trial[k] >= {1'b0, den_reg[k]};
            rem_next[k] = fits[k] ? DW'(trial[k] - {1'b0, den_reg[k]}) : DW'(trial[k]);
        end
    end

    // high part at or above the divisor: quotient needs more than QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num[NW-1:QB]);
            low_reg[0] <= num[QB-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            big_reg[0] <= CW'(num[NW-1:QB]) >= CW'(den);
            for (int k = 0; k < QB; k++)
            begin
                if (k < QB - 1)
                begin
                    rem_reg[k+1] <= rem_next[k];
                    low_reg[k+1] <= low_reg[k] << 1;
                    den_reg[k+1] <= den_reg[k];
                end
                q_reg[k+1]   <= {q_reg[k][QB-2:0], fits[k]};
                big_reg[k+1] <= big_reg[k];
            end
        end
    end

    assign quo = q_reg[QB];
    assign big = big_reg[QB];

endmodule

// ===== rtl/core/rwpc_checker.sv =====
// ----------------------------------------------------------------------------
// rwpc_checker
// Port-level checks for the ray/wall crossing block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwpc_checker
    import rwpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      ray_valid,
    input logic      ray_stall,
    input logic      hit_valid,
    input logic      hit_stall,
    input hit_beat_t hit_beat
);

    // a stalled hit beat stays put
    `RWPC_ASSERT_NEXT(a_hit_hold, hit_valid && hit_stall, hit_valid && $stable(hit_beat), "hit beat changed while stalled")

    // the pipeline only backs up when the hit side holds a beat
    `RWPC_ASSERT_NOW(a_stall_cause, ray_stall, hit_valid && hit_stall, "ray stalled without downstream stall")

    // one Jacobian entry is always exactly one
    `RWPC_ASSERT_NOW(a_unit_jac, hit_valid, (hit_beat.jac_x == 32'sd65536) || (hit_beat.jac_y == 32'sd65536), "no unit Jacobian entry")

    // a ray offered with an idle output never waits
    `RWPC_ASSERT_NOW(a_no_wait, ray_valid && !hit_valid, !ray_stall, "ray stalled with empty output")

endmodule

bind ray_wall_plane_crossing rwpc_checker u_rwpc_checker (.*);

// ===== sim/ray_wall_plane_crossing_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_wall_plane_crossing_tb
// Drives pose/sensor/wall beats into the crossing block and checks every hit
// beat against a bit-true in-bench model of the CORDIC, mount transform,
// plane crossing and saturation. Mounts are reprogrammed over APB between
// phases while the pipe is drained.
// ----------------------------------------------------------------------------
module ray_wall_plane_crossing_tb;
    import rwpc_pkg::*;

    localparam int STAGES    = 16;
    localparam int SENSORS   = 4;
    localparam int PIPE_WAIT = STAGES + 80;
    localparam longint QLIM  = 64'sd35184372088832;
    localparam int ADDR_STEP = 8;
    localparam int HOLD_LEN  = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        ray_valid = 1'b0;
    logic        ray_stall;
    ray_beat_t   ray_beat = '0;
    logic        hit_valid;
    logic        hit_stall = 1'b0;
    hit_beat_t   hit_beat;

    ray_wall_plane_crossing #(.NUM_SENSORS(SENSORS), .CORDIC_STAGES(STAGES)) dut (.*);

    always #10 clk = ~clk;

    // bench copy of the mounting registers
    logic [47:0] mount_q [SENSORS];

    ray_beat_t pending_rays[$];
    hit_beat_t expected_hits[$];
    int        error_count = 0;
    bit        random_idle = 1'b0;   // idle gaps only when set
    bit        ray_taken = 1'b0;     // ray beat taken at the last rising edge
    bit        hold_start = 1'b0;    // kicks off the long receiver hold-off
    int        hold_count = 0;
    bit        hold_off = 1'b0;

    function automatic longint fl(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic void cordic(input logic [15:0] ang, output longint c,
                                   output longint s);
        logic [31:0] a;
        longint x, y, z, dx, dy;
        bit flip;
        a = {ang, 16'h0};
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a = a + 32'h8000_0000;
        x = 652032874; y = 0;
        z = longint'(signed'(a));
        for (int i = 0; i < STAGES; i++)
        begin
            dx = fl(y, i); dy = fl(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_step(i[4:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_step(i[4:0]));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // trunc(num * 2^shift / den), clamped to the quotient limit
    function automatic longint quot(input longint num, input longint den, input int shift,
                                    inout bit sat);
        bit neg;
        logic [63:0] un, ud, q, r;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        if (ud == 0)
        begin
            sat = 1'b1; q = QLIM;
        end
        else
        begin
            q = un / ud; r = un % ud;
            for (int k = 0; k < shift && q <= QLIM; k++)
            begin
                r = r << 1; q = q << 1;
                if (r >= ud)
                begin
                    r -= ud; q[0] = 1'b1;
                end
            end
            if (q > QLIM)
            begin
                q = QLIM; sat = 1'b1;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp32(input longint v, input int drop, inout bit sat);
        longint w;
        w = fl(v, drop);
        if (w > 64'sd2147483647)
        begin
            w = 64'sd2147483647; sat = 1'b1;
        end
        if (w < -64'sd2147483648)
        begin
            w = -64'sd2147483648; sat = 1'b1;
        end
        return w[31:0];
    endfunction

    function automatic hit_beat_t crossing_of(input ray_beat_t rb);
        hit_beat_t h;
        bit sat, vert;
        logic [47:0] m;
        longint px, py, face, base, mx, my, ch, sh, dc, ds, ox, oy;
        longint across, along, gap, start, lx, ly, offset, range, slope, swing, jh;
        px = longint'(rb.pose_x) * 256;
        py = longint'(rb.pose_y) * 256;
        face = longint'(rb.wall_face) * 256;
        base = longint'(rb.wall_base) * 256;
        vert = rb.wall_vertical;
        sat = 1'b0;
        m = mount_q[(rb.sensor_index >= SENSORS) ? SENSORS - 1 : rb.sensor_index];
        mx = longint'(signed'(m[15:0]));
        my = longint'(signed'(m[31:16]));
        cordic(rb.pose_heading, ch, sh);
        ox = px + fl(mx * ch - my * sh, 22);
        oy = py + fl(mx * sh + my * ch, 22);
        cordic(rb.pose_heading + m[47:32], dc, ds);
        across = vert ? dc : ds;
        along = vert ? ds : dc;
        if (across > -16384 && across < 16384)
        begin
            across = across < 0 ? -16384 : 16384;
            sat = 1'b1;
        end
        gap = face - (vert ? ox : oy);
        start = vert ? oy : ox;
        lx = ox - px;
        ly = oy - py;
        offset = start - base + quot(gap * along, across, 0, sat);
        range = quot(gap, across, 30, sat);
        slope = quot(along, across, 16, sat);
        swing = quot(gap, across * across, 60, sat);
        h.hit_offset = clamp32(offset, 4, sat);
        h.ray_range = clamp32(range, 4, sat);
        if (vert)
        begin
            jh = lx + quot(ly * along, across, 0, sat) + swing;
            h.jac_x = clamp32(-slope, 0, sat);
            h.jac_y = clamp32(65536, 0, sat);
        end
        else
        begin
            jh = -ly - quot(lx * along, across, 0, sat) - swing;
            h.jac_x = clamp32(65536, 0, sat);
            h.jac_y = clamp32(-slope, 0, sat);
        end
        h.jac_heading = clamp32(jh, 4, sat);
        h.saturated = sat;
        return h;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // long receiver hold-off, counted on its own
    always @(negedge clk)
    begin
        if (hold_start && hold_count < HOLD_LEN)
        begin
            hold_off <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            hold_off <= 1'b0;
    end

    // driver: beats change on the falling edge; a beat holds until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!ray_valid || ray_taken)
            begin
                if (pending_rays.size() > 0 && !(random_idle && $urandom_range(99) < 30))
                begin
                    ray_beat <= pending_rays.pop_front();
                    ray_valid <= 1'b1;
                end
                else
                    ray_valid <= 1'b0;
            end
            hit_stall <= hold_off || (random_idle && ($urandom_range(99) < 30));
        end
    end

    // predictions are made when the ray beat is taken
    always @(posedge clk)
    begin
        ray_taken = rst_n && ray_valid && !ray_stall;
        if (ray_taken)
            expected_hits.push_back(crossing_of(ray_beat));
    end

    // monitor
    always @(posedge clk)
    begin
        hit_beat_t want;
        if (rst_n && hit_valid && !hit_stall)
        begin
            if (expected_hits.size() == 0)
                report("unexpected hit beat", hit_beat.hit_offset, 32'h0);
            else
            begin
                want = expected_hits.pop_front();
                if (hit_beat.hit_offset !== want.hit_offset)
                    report("hit_offset", hit_beat.hit_offset, want.hit_offset);
                if (hit_beat.ray_range !== want.ray_range)
                    report("ray_range", hit_beat.ray_range, want.ray_range);
                if (hit_beat.jac_x !== want.jac_x)
                    report("jac_x", hit_beat.jac_x, want.jac_x);
                if (hit_beat.jac_y !== want.jac_y)
                    report("jac_y", hit_beat.jac_y, want.jac_y);
                if (hit_beat.jac_heading !== want.jac_heading)
                    report("jac_heading", hit_beat.jac_heading, want.jac_heading);
                if (hit_beat.saturated !== want.saturated)
                    report("saturated", 32'(hit_beat.saturated), 32'(want.saturated));
            end
        end
    end

    // APB write, setup then access phase
    task automatic write_mount(input int idx, input logic [47:0] value);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx * ADDR_STEP); pwdata <= {16'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        mount_q[idx] = value;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain;
        while (pending_rays.size() > 0 || expected_hits.size() > 0)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    function automatic logic [15:0] pick16;
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // headings land on axis-aligned angles often, to hit the near-zero divisor
    function automatic logic [15:0] pick_angle;
        logic [15:0] a;
        a = {2'($urandom_range(3)), 14'h0};
        case ($urandom_range(3))
            0: return a;
            1: return a + 16'($urandom_range(6)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ray_beat_t random_ray;
        ray_beat_t r;
        r.pose_x = pick16();
        r.pose_y = pick16();
        r.pose_heading = pick_angle();
        r.sensor_index = 2'($urandom_range(3));
        r.wall_vertical = 1'($urandom_range(1));
        r.wall_face = pick16();
        r.wall_base = pick16();
        return r;
    endfunction

    initial
    begin
        ray_beat_t r;
        for (int i = 0; i < SENSORS; i++) mount_q[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: reset mounts, field extremes, both walls, axis headings, a diagonal ray per wall
        for (int i = 0; i < 16; i++)
        begin
            r.pose_x = (i & 1) ? 16'sh7FFF : 16'sh8000;
            r.pose_y = (i & 2) ? 16'sh7FFF : 16'sh8000;
            r.pose_heading = 16'(i * 16'h4000) ^ ((i & 8) ? 16'hFFFF : 16'h0);
            r.sensor_index = 2'(i);
            r.wall_vertical = i[2];
            r.wall_face = (i & 4) ? 16'sh7FFF : 16'sh8000;
            r.wall_base = (i & 8) ? 16'sh8000 : 16'sh0;
            pending_rays.push_back(r);
        end
        r = '0; r.pose_heading = 16'h2000; r.wall_face = 16'sh1000;
        pending_rays.push_back(r);
        r.wall_vertical = 1'b1;
        pending_rays.push_back(r);
        drain();

        // phases with different mounts, including all-ones and field extremes
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int s = 0; s < SENSORS; s++)
                case (ph)
                    0: write_mount(s, 48'hFFFF_FFFF_FFFF);
                    1: write_mount(s, {16'h8000, 16'h7FFF, 16'h8000});
                    2: write_mount(s, {16'(s * 16'h4000), 16'h0400, 16'hFC00});
                    default: write_mount(s, {16'($urandom), 16'($urandom), 16'($urandom)});
                endcase
            random_idle = (ph != 1);
            for (int i = 0; i < 150; i++) pending_rays.push_back(random_ray());
            if (ph == 2)
                hold_start = 1'b1;   // receiver holds off while rays keep coming
            drain();
        end
        write_mount(0, '0);

        if (error_count == 0)
            $display("ray_wall_plane_crossing_tb OK");
        else
            $display("ray_wall_plane_crossing_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("ray_wall_plane_crossing_tb NOT OK");
        $finish;
    end

endmodule
